[design/lcal_pkg.sv]
// Shared constants, sequencer step codes and handshake structs for the
// binary-lifting LCA engine. No dependencies.
`default_nettype none
package lcal_pkg;
   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 11;
   localparam int NODE_W    = 10;
   localparam int LVL_W     = 4;
   localparam int CNT_W     = 11;
   localparam int DEPTH_W   = 10;
   localparam int SUM_W     = 12;
   localparam int ACT_W     = 3;
   localparam int JT_AW     = LVL_W + NODE_W;
   localparam int JT_DEPTH  = LEVELS * MAX_NODES;
   localparam int STATE_W   = 5;

   localparam logic [ACT_W-1:0] ACT_SET_PARENT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SET_DEPTH  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DEPTHS     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_BUILD      = 3'd3;
   localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd4;

   localparam logic [STATE_W-1:0] S_IDLE = 5'd0;
   localparam logic [STATE_W-1:0] S_B0   = 5'd1;
   localparam logic [STATE_W-1:0] S_B1   = 5'd2;
   localparam logic [STATE_W-1:0] S_B2   = 5'd3;
   localparam logic [STATE_W-1:0] S_D0   = 5'd4;
   localparam logic [STATE_W-1:0] S_D1   = 5'd5;
   localparam logic [STATE_W-1:0] S_D2   = 5'd6;
   localparam logic [STATE_W-1:0] S_D3   = 5'd7;
   localparam logic [STATE_W-1:0] S_D4   = 5'd8;
   localparam logic [STATE_W-1:0] S_Q0   = 5'd9;
   localparam logic [STATE_W-1:0] S_Q1   = 5'd10;
   localparam logic [STATE_W-1:0] S_Q2   = 5'd11;
   localparam logic [STATE_W-1:0] S_Q3   = 5'd12;
   localparam logic [STATE_W-1:0] S_Q4   = 5'd13;
   localparam logic [STATE_W-1:0] S_Q5   = 5'd14;
   localparam logic [STATE_W-1:0] S_Q6   = 5'd15;
   localparam logic [STATE_W-1:0] S_Q7   = 5'd16;
   localparam logic [STATE_W-1:0] S_Q8   = 5'd17;
   localparam logic [STATE_W-1:0] S_Q9   = 5'd18;
   localparam logic [STATE_W-1:0] S_Q10  = 5'd19;
   localparam logic [STATE_W-1:0] S_Q11  = 5'd20;
   localparam logic [STATE_W-1:0] S_OUT  = 5'd21;

   typedef struct packed {
      logic [STATE_W-1:0] op;
      logic               accept;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic node_last;
      logic lvl_zero;
      logic lvl_top;
      logic depth_eq;
      logic xy_eq;
      logic out_free;
   } status_type;
endpackage
`default_nettype wire

[design/lcal_ctrl.sv]
// Sequencer for the LCA engine: walks the build, depth and query steps.
// Depends on lcal_pkg; drives the datapath through cmd_type.
`default_nettype none
module lcal_ctrl
   import lcal_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [ACT_W-1:0] req_action,
   output logic                  req_ready,
   input  wire status_type       status,
   output cmd_type               cmd
);
   logic [STATE_W-1:0] state_ff, state_in;

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.op     = state_ff;
   assign cmd.accept = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  ACT_DEPTHS: state_in = status.cnt_zero ? S_IDLE : S_D0;
                  ACT_BUILD:  state_in = status.cnt_zero ? S_IDLE : S_B0;
                  ACT_QUERY:  state_in = S_Q0;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_B0:  state_in = S_B1;
         S_B1:  state_in = S_B2;
         S_B2:  state_in = (status.node_last && status.lvl_top) ? S_IDLE : S_B0;
         S_D0:  state_in = S_D1;
         S_D1:  state_in = S_D2;
         S_D2:  state_in = status.lvl_zero ? S_D3 : S_D0;
         S_D3:  state_in = S_D4;
         S_D4:  state_in = status.node_last ? S_IDLE : S_D0;
         S_Q0:  state_in = S_Q1;
         S_Q1:  state_in = S_Q2;
         S_Q2:  state_in = status.depth_eq ? S_Q6 : S_Q3;
         S_Q3:  state_in = S_Q4;
         S_Q4:  state_in = S_Q5;
         S_Q5:  state_in = status.lvl_zero ? S_Q6 : S_Q3;
         S_Q6:  state_in = status.xy_eq ? S_OUT : S_Q7;
         S_Q7:  state_in = S_Q8;
         S_Q8:  state_in = S_Q9;
         S_Q9:  state_in = status.lvl_zero ? S_Q10 : S_Q7;
         S_Q10: state_in = S_Q11;
         S_Q11: state_in = S_OUT;
         S_OUT: state_in = status.out_free ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

[design/lcal_dp.sv]
// Datapath of the LCA engine: jump table and depth memories, walk registers,
// result register. Depends on lcal_pkg; steered by lcal_ctrl.
`default_nettype none
module lcal_dp
   import lcal_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [NODE_W-1:0]  req_node_a,
   input  wire logic [NODE_W-1:0]  req_node_b,
   input  wire logic [DEPTH_W-1:0] req_depth_value,
   input  wire logic               csr_wr_en,
   input  wire logic [CNT_W-1:0]   csr_wr_data,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [NODE_W-1:0]       rsp_ancestor,
   output status_type              status
);
   logic [NODE_W-1:0]  jt_mem [JT_DEPTH];
   logic [DEPTH_W-1:0] dm_mem [MAX_NODES];

   logic [NODE_W-1:0]  jt_rd_ff;
   logic [DEPTH_W-1:0] dm_rd_ff;
   logic [CNT_W-1:0]   node_count_ff;
   logic [NODE_W-1:0]  x_ff, x_in, y_ff, y_in, a_ff, a_in;
   logic [DEPTH_W-1:0] dx_ff, dx_in;
   logic [SUM_W-1:0]   d_ff, d_in, d_next;
   logic [LVL_W-1:0]   lvl_ff, lvl_in, lvl_dec;
   logic [CNT_W-1:0]   idx_ff, idx_in, idx_inc;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]  rsp_anc_ff, rsp_anc_in;

   logic [CNT_W-1:0]   active_cnt;
   logic [JT_AW-1:0]   jt_raddr, jt_waddr;
   logic [NODE_W-1:0]  jt_wdata, dm_raddr, dm_waddr;
   logic [DEPTH_W-1:0] dm_wdata;
   logic               jt_we, dm_we;

   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

   assign active_cnt = (node_count_ff > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : node_count_ff;
   assign idx_inc = idx_ff + CNT_W'(1);
   assign lvl_dec = lvl_ff - LVL_W'(1);
   assign d_next  = (jt_rd_ff == x_ff) ? '0 : d_ff + SUM_W'(1);

   assign status.cnt_zero  = (active_cnt == '0);
   assign status.node_last = (idx_inc == active_cnt);
   assign status.lvl_zero  = (lvl_ff == '0);
   assign status.lvl_top   = (lvl_ff == LVL_TOP);
   assign status.depth_eq  = (dx_ff == dm_rd_ff);
   assign status.xy_eq     = (x_ff == y_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;

   // Memory addressing per step.
   always_comb begin
      jt_raddr = '0;
      dm_raddr = '0;
      jt_we    = 1'b0;
      jt_waddr = {LVL_W'(0), req_node_a};
      jt_wdata = req_node_b;
      dm_we    = 1'b0;
      dm_waddr = req_node_a;
      dm_wdata = req_depth_value;
      unique case (cmd.op)
         S_IDLE: begin
            jt_we = cmd.accept && (req_action == ACT_SET_PARENT);
            dm_we = cmd.accept && (req_action == ACT_SET_DEPTH);
         end
         S_B0:  jt_raddr = {lvl_dec, idx_ff[NODE_W-1:0]};
         S_B1:  jt_raddr = {lvl_dec, jt_rd_ff};
         S_B2: begin
            jt_we    = 1'b1;
            jt_waddr = {lvl_ff, idx_ff[NODE_W-1:0]};
            jt_wdata = jt_rd_ff;
         end
         S_D0:  jt_raddr = {lvl_ff, x_ff};
         S_D1:  jt_raddr = {LVL_W'(0), jt_rd_ff};
         S_D3:  jt_raddr = {LVL_W'(0), x_ff};
         S_D4: begin
            dm_we    = 1'b1;
            dm_waddr = idx_ff[NODE_W-1:0];
            dm_wdata = (d_next > SUM_W'(MAX_NODES - 1)) ? DEPTH_W'(MAX_NODES - 1)
                                                         : d_next[DEPTH_W-1:0];
         end
         S_Q0:  dm_raddr = x_ff;
         S_Q1:  dm_raddr = y_ff;
         S_Q3:  jt_raddr = {lvl_ff, y_ff};
         S_Q4:  dm_raddr = jt_rd_ff;
         S_Q7:  jt_raddr = {lvl_ff, x_ff};
         S_Q8:  jt_raddr = {lvl_ff, y_ff};
         S_Q10: jt_raddr = {LVL_W'(0), x_ff};
         default: ;
      endcase
   end

   // Walk register updates.
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      a_in         = a_ff;
      dx_in        = dx_ff;
      d_in         = d_ff;
      lvl_in       = lvl_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_anc_in   = rsp_anc_ff;
      unique case (cmd.op)
         S_IDLE: begin
            if (cmd.accept) begin
               x_in   = (req_action == ACT_QUERY) ? req_node_a : '0;
               y_in   = req_node_b;
               idx_in = '0;
               d_in   = '0;
               lvl_in = (req_action == ACT_BUILD) ? LVL_W'(1) : LVL_TOP;
            end
         end
         S_B2: begin
            if (status.node_last) begin
               idx_in = '0;
               lvl_in = status.lvl_top ? lvl_ff : lvl_ff + LVL_W'(1);
            end else begin
               idx_in = idx_inc;
            end
         end
         S_D1: a_in = jt_rd_ff;
         S_D2: begin
            if (jt_rd_ff != a_ff) begin
               d_in = d_ff + (SUM_W'(1) << lvl_ff);
               x_in = a_ff;
            end
            if (!status.lvl_zero) lvl_in = lvl_dec;
         end
         S_D4: begin
            idx_in = status.node_last ? '0 : idx_inc;
            x_in   = idx_inc[NODE_W-1:0];
            d_in   = '0;
            lvl_in = LVL_TOP;
         end
         S_Q1: dx_in = dm_rd_ff;
         S_Q2: begin
            lvl_in = LVL_TOP;
            if (dx_ff > dm_rd_ff) begin
               x_in  = y_ff;
               y_in  = x_ff;
               dx_in = dm_rd_ff;
            end
         end
         S_Q4: a_in = jt_rd_ff;
         S_Q5: begin
            if (dm_rd_ff >= dx_ff) y_in = a_ff;
            if (!status.lvl_zero) lvl_in = lvl_dec;
         end
         S_Q6: begin
            a_in   = x_ff;
            lvl_in = LVL_TOP;
         end
         S_Q8: a_in = jt_rd_ff;
         S_Q9: begin
            if (a_ff != jt_rd_ff) begin
               x_in = a_ff;
               y_in = jt_rd_ff;
            end
            if (!status.lvl_zero) lvl_in = lvl_dec;
         end
         S_Q11: a_in = jt_rd_ff;
         S_OUT: begin
            if (status.out_free) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = a_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (jt_we) jt_mem[jt_waddr] <= jt_wdata;
      jt_rd_ff <= jt_mem[jt_raddr];
   end

   always_ff @(posedge clock) begin
      if (dm_we) dm_mem[dm_waddr] <= dm_wdata;
      dm_rd_ff <= dm_mem[dm_raddr];
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      a_ff       <= a_in;
      dx_ff      <= dx_in;
      d_ff       <= d_in;
      rsp_anc_ff <= rsp_anc_in;
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= CNT_W'(MAX_NODES);
         lvl_ff        <= '0;
         idx_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
         idx_ff       <= idx_in;
         if (csr_wr_en) node_count_ff <= csr_wr_data;
      end
   end

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff < LVL_W'(LEVELS))
      else $error("lifting level out of range");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff < CNT_W'(MAX_NODES))
      else $error("node sweep index out of range");
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == S_OUT))
      else $error("response raised outside the output step");
endmodule
`default_nettype wire

[design/lowest_common_ancestor_lifting_top.sv]
// Top level of the binary-lifting LCA engine.
// Depends on lcal_pkg, lcal_ctrl and lcal_dp.
// A parent or depth load is written as the request is accepted. A query
// reads both depths, climbs the deeper node to equal depth (skipped at equal
// depths), then climbs both nodes jointly and reads the final parent (skipped
// when one node is the other's ancestor); these climbs share the single
// jump-table read port. A table build sweeps every node for each level above
// 0; a depth pass climbs each node level by level. One request at a time.
// Reset: synchronous, clears the sequencer, the response flag, the level and
// index counters and sets node_count to 1024; the jump table and depth memories are not cleared.
`default_nettype none
module lowest_common_ancestor_lifting_top
   import lcal_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [NODE_W-1:0]  req_node_a,
   input  wire logic [NODE_W-1:0]  req_node_b,
   input  wire logic [DEPTH_W-1:0] req_depth_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [NODE_W-1:0]       rsp_ancestor,
   input  wire logic               csr_wr_en,
   input  wire logic [CNT_W-1:0]   csr_wr_data
);
   cmd_type    cmd;
   status_type status;

   // The sequencer owns request acceptance; the datapath owns all storage.
   lcal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The response register decouples the result from the next request.
   lcal_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .req_depth_value (req_depth_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ancestor    (rsp_ancestor),
      .status          (status)
   );
endmodule
`default_nettype wire
